FILE: src/round_robin_ready_queue_core_assert.svh
// Assertion macros for the run queue checker.
`ifndef ROUND_ROBIN_READY_QUEUE_CORE_ASSERT_SVH
`define ROUND_ROBIN_READY_QUEUE_CORE_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define RRQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("run queue check failed");

// Clocked check that also holds during reset.
`define RRQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("run queue check failed during reset");

`endif

FILE: src/rrq_pkg.sv
// Package for the round-robin run queue: constants, codes and payload types.
package rrq_pkg;

  // Default number of task IDs accepted.
  localparam int unsigned TASK_COUNT = 64;

  // Ring geometry: 64 slots, one always left free.
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_AW    = 6;
  localparam int unsigned ID_W       = 6;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_PICK     = 3'd0,
    CMD_READY    = 3'd1,
    CMD_UNREADY  = 3'd2,
    CMD_BLOCK    = 3'd3,
    CMD_UNBLOCK  = 3'd4,
    CMD_YIELD    = 3'd5,
    CMD_HANDOFF  = 3'd6
  } cmd_e;

  // Status codes.
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BAD_ID = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  // Input item.
  typedef struct packed {
    logic [2:0]      command;
    logic [7:0]      task_id;
    logic [ID_W-1:0] wait_target;
    logic            wait_target_valid;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [ID_W-1:0]    current_task;
    logic               current_valid;
    logic [1:0]         status;
    logic [ID_W-1:0]    released_target;
    logic               released_valid;
    logic [RING_AW-1:0] queue_count;
  } out_t;

endpackage

FILE: src/round_robin_ready_queue_core.sv
// Round-robin run queue: ring of ready task IDs, current task and wait targets.
//   Input channel in_valid_i / in_stall_o carries one command item (pick, ready,
//   unready, block, unblock, yield, handoff); output channel out_valid_o /
//   out_stall_i returns exactly one result item per command. An item moves at
//   a clock edge where valid is high and stall is low.
//   One item is worked at a time; in_stall_o stays high until its result has
//   been loaded into the output register. The ring is walked by one sequencer
//   through a single-port memory read, one entry per cycle. Bad ID and unknown
//   commands go straight to the result; pick reads the head entry; ready,
//   unready, block and unblock walk the ring once at most; yield walks it at
//   most once and then picks; handoff walks it at most twice. With the ring at
//   its 63-entry limit the walks are longest; the next command is accepted in
//   the cycle after a result is loaded.
//   A finished result waits in the output register while the receiver stalls;
//   a new command is taken meanwhile, and its result is held back until the
//   previous one has been taken.
//   Reset empties the ring, clears the current task and all wait targets at
//   once; the block accepts a command in the first cycle after reset.
module round_robin_ready_queue_core #(
  parameter int unsigned TASK_COUNT = rrq_pkg::TASK_COUNT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rrq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rrq_pkg::out_t out_data_o
);

  localparam int unsigned WAIT_DEPTH = (TASK_COUNT < rrq_pkg::RING_DEPTH) ?
                                       TASK_COUNT : rrq_pkg::RING_DEPTH;
  localparam int unsigned WAIT_AW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

  typedef logic [rrq_pkg::RING_AW-1:0] ptr_t;
  typedef logic [rrq_pkg::ID_W-1:0]    id_t;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_LOAD_ENQ  = 8'b0000_0010,
    ST_ENQ       = 8'b0000_0100,
    ST_LOAD_REM  = 8'b0000_1000,
    ST_REM       = 8'b0001_0000,
    ST_LOAD_PICK = 8'b0010_0000,
    ST_PICK      = 8'b0100_0000,
    ST_OUT       = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  ptr_t          head_q, head_d;
  ptr_t          tail_q, tail_d;
  id_t           run_task_q, run_task_d;
  logic          run_valid_q, run_valid_d;
  logic          out_valid_q, out_valid_d;
  logic [WAIT_DEPTH-1:0] wv_q, wv_d;

  logic [2:0]    cmd_q, cmd_d;
  id_t           id_q, id_d;
  id_t           enq_id_q, enq_id_d;
  ptr_t          rd_ptr_q, rd_ptr_d;
  ptr_t          wr_ptr_q, wr_ptr_d;
  logic [1:0]    status_q, status_d;
  logic          rel_v_q, rel_v_d;
  rrq_pkg::out_t out_q, out_d;

  // Ring memory, one write and one registered read port.
  id_t           ring_q [rrq_pkg::RING_DEPTH];
  id_t           ring_rd_q;
  logic          ring_we;
  ptr_t          ring_waddr;
  id_t           ring_wdata;
  ptr_t          ring_raddr;

  // Wait-target memory; the valid bits live in wv_q.
  id_t           wt_q [WAIT_DEPTH];
  id_t           wt_rd_q;
  logic          wt_we;
  logic          wt_re;
  logic [WAIT_AW-1:0] wt_addr;

  logic          in_acc;
  logic          uses_id;
  logic          id_ok;
  id_t           in_id;
  logic          ring_full;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_id     = in_data_i.task_id[rrq_pkg::ID_W-1:0];
  assign wt_addr   = in_data_i.task_id[WAIT_AW-1:0];
  assign ring_full = ((tail_q + ptr_t'(1)) == head_q);

  assign id_ok   = ({1'b0, in_data_i.task_id} < 9'(TASK_COUNT)) &&
                   ({1'b0, in_data_i.task_id} < 9'(rrq_pkg::RING_DEPTH));
  assign uses_id = (in_data_i.command == rrq_pkg::CMD_READY)   ||
                   (in_data_i.command == rrq_pkg::CMD_UNREADY) ||
                   (in_data_i.command == rrq_pkg::CMD_BLOCK)   ||
                   (in_data_i.command == rrq_pkg::CMD_UNBLOCK) ||
                   (in_data_i.command == rrq_pkg::CMD_HANDOFF);

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    run_task_d  = run_task_q;
    run_valid_d = run_valid_q;
    out_valid_d = out_valid_q;
    wv_d        = wv_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    enq_id_d    = enq_id_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    status_d    = status_q;
    rel_v_d     = rel_v_q;
    out_d       = out_q;
    ring_we     = 1'b0;
    ring_waddr  = tail_q;
    ring_wdata  = enq_id_q;
    ring_raddr  = head_q;
    wt_we       = 1'b0;
    wt_re       = 1'b0;

    // Drop the result once the receiver takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d    = in_data_i.command;
          id_d     = in_id;
          status_d = rrq_pkg::STATUS_OK;
          rel_v_d  = 1'b0;
          if (uses_id && !id_ok) begin
            status_d = rrq_pkg::STATUS_BAD_ID;
            state_d  = ST_OUT;
          end else begin
            case (in_data_i.command)
              rrq_pkg::CMD_PICK: begin
                state_d = ST_LOAD_PICK;
              end
              rrq_pkg::CMD_READY: begin
                enq_id_d = in_id;
                state_d  = ST_LOAD_ENQ;
              end
              rrq_pkg::CMD_UNREADY: begin
                state_d = ST_LOAD_REM;
              end
              rrq_pkg::CMD_BLOCK: begin
                wt_we            = 1'b1;
                wv_d[wt_addr]    = in_data_i.wait_target_valid;
                state_d          = ST_LOAD_REM;
              end
              rrq_pkg::CMD_UNBLOCK: begin
                wt_re         = 1'b1;
                rel_v_d       = wv_q[wt_addr];
                wv_d[wt_addr] = 1'b0;
                enq_id_d      = in_id;
                state_d       = ST_LOAD_ENQ;
              end
              rrq_pkg::CMD_YIELD: begin
                enq_id_d = run_task_q;
                state_d  = run_valid_q ? ST_LOAD_ENQ : ST_LOAD_PICK;
              end
              rrq_pkg::CMD_HANDOFF: begin
                enq_id_d = run_task_q;
                state_d  = run_valid_q ? ST_LOAD_ENQ : ST_LOAD_REM;
              end
              default: begin
                state_d = ST_OUT;
              end
            endcase
          end
        end
      end

      // Start a duplicate search at the head.
      ST_LOAD_ENQ: begin
        ring_raddr = head_q;
        rd_ptr_d   = head_q;
        state_d    = ST_ENQ;
      end

      // Walk the ring for a copy; if none is found, append at the tail unless the ring is full.
      ST_ENQ: begin
        ring_raddr = rd_ptr_q + ptr_t'(1);
        if (rd_ptr_q == tail_q || ring_rd_q == enq_id_q) begin
          if (rd_ptr_q == tail_q) begin
            if (ring_full) begin
              status_d = rrq_pkg::STATUS_FULL;
            end else begin
              ring_we    = 1'b1;
              ring_waddr = tail_q;
              ring_wdata = enq_id_q;
              tail_d     = tail_q + ptr_t'(1);
            end
          end
          case (cmd_q)
            rrq_pkg::CMD_YIELD:   state_d = ST_LOAD_PICK;
            rrq_pkg::CMD_HANDOFF: state_d = ST_LOAD_REM;
            default:              state_d = ST_OUT;
          endcase
        end else begin
          rd_ptr_d = rd_ptr_q + ptr_t'(1);
        end
      end

      // Start a compacting pass at the head.
      ST_LOAD_REM: begin
        ring_raddr = head_q;
        rd_ptr_d   = head_q;
        wr_ptr_d   = head_q;
        state_d    = ST_REM;
      end

      // Copy every entry that is not the removed ID down to the write pointer; a handoff then makes the ID current.
      ST_REM: begin
        ring_raddr = rd_ptr_q + ptr_t'(1);
        if (rd_ptr_q == tail_q) begin
          tail_d = wr_ptr_q;
          if (cmd_q == rrq_pkg::CMD_HANDOFF) begin
            run_task_d  = id_q;
            run_valid_d = 1'b1;
          end
          state_d = ST_OUT;
        end else begin
          if (ring_rd_q != id_q) begin
            ring_we    = 1'b1;
            ring_waddr = wr_ptr_q;
            ring_wdata = ring_rd_q;
            wr_ptr_d   = wr_ptr_q + ptr_t'(1);
          end
          rd_ptr_d = rd_ptr_q + ptr_t'(1);
        end
      end

      // Fetch the head entry.
      ST_LOAD_PICK: begin
        ring_raddr = head_q;
        state_d    = ST_PICK;
      end

      // Make the head current, or clear the current task on an empty ring.
      ST_PICK: begin
        if (head_q == tail_q) begin
          run_task_d  = '0;
          run_valid_d = 1'b0;
        end else begin
          run_task_d  = ring_rd_q;
          run_valid_d = 1'b1;
          head_d      = head_q + ptr_t'(1);
        end
        state_d = ST_OUT;
      end

      // Load the result once the output register is free.
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.current_task    = run_valid_q ? run_task_q : '0;
          out_d.current_valid   = run_valid_q;
          out_d.status          = status_q;
          out_d.released_target = rel_v_q ? wt_rd_q : '0;
          out_d.released_valid  = rel_v_q;
          out_d.queue_count     = tail_q - head_q;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      run_task_q  <= '0;
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      wv_q        <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      run_task_q  <= run_task_d;
      run_valid_q <= run_valid_d;
      out_valid_q <= out_valid_d;
      wv_q        <= wv_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    id_q     <= id_d;
    enq_id_q <= enq_id_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    status_q <= status_d;
    rel_v_q  <= rel_v_d;
    out_q    <= out_d;
  end

  // Ring memory.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[ring_waddr] <= ring_wdata;
    end
    ring_rd_q <= ring_q[ring_raddr];
  end

  // Wait-target memory; hold the read data until the next unblock.
  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_q[wt_addr] <= in_data_i.wait_target;
    end
    if (wt_re) begin
      wt_rd_q <= wt_q[wt_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/rrq_checker.sv
// Port-level checker for the run queue, bound to the top level.
`include "round_robin_ready_queue_core_assert.svh"

module rrq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input rrq_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rrq_pkg::out_t out_data_o
);

  // A stalled result holds.
  `RRQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // A stalled command item holds.
  `RRQ_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))

  // One command at a time: the block is busy right after taking an item.
  `RRQ_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)

  // Idle results show task zero, results without a release show target zero, and status 3 never appears.
  `RRQ_ASSERT(a_idle_zero, clk_i, rst_ni, out_valid_o |-> (out_data_o.current_valid || out_data_o.current_task == '0) && (out_data_o.released_valid || out_data_o.released_target == '0) && out_data_o.status != 2'd3)

  // No result is offered once reset has been sampled low.
  `RRQ_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind round_robin_ready_queue_core rrq_checker u_rrq_checker (.*);
